// ===== design/backlight_keepalive_dimmer_pwm_macros.svh =====
// Assertion macros for the backlight dimmer top-level design file.
`ifndef BACKLIGHT_KEEPALIVE_DIMMER_PWM_MACROS_SVH
`define BACKLIGHT_KEEPALIVE_DIMMER_PWM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BKD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BKD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/bkd_pkg.sv =====
// Types and constants for the backlight keep-alive dimmer.
package bkd_pkg;

  localparam int DUTY_W = 4;
  localparam logic [DUTY_W-1:0] PWM_STEPS = 4'd12;
  localparam int CFG_W = 16;

  // Configuration register indexes
  localparam logic CFG_KEEPALIVE = 1'b0;
  localparam logic CFG_DIM_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ARMED    = 2'd1,
    PH_COUNTING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DIM  = 2'd1,
    EV_HOLD = 2'd2
  } dim_event_t;

  typedef struct packed {
    logic wake;
    logic slow_tick;
    logic fast_tick;
  } item_t;

  typedef struct packed {
    logic              backlight_on;
    logic [DUTY_W-1:0] duty_level;
    logic              dim_done;
  } result_t;

endpackage

// ===== design/bkd_if.sv =====
// Valid/ready channel interfaces for input items and results.
interface bkd_in_if;
  logic valid;
  logic ready;
  logic wake;
  logic slow_tick;
  logic fast_tick;

  modport source (output valid, output wake, output slow_tick, output fast_tick,
                  input ready);
  modport sink (input valid, input wake, input slow_tick, input fast_tick,
                output ready);
endinterface

interface bkd_out_if;
  logic       valid;
  logic       ready;
  logic       backlight_on;
  logic [3:0] duty_level;
  logic       dim_done;

  modport source (output valid, output backlight_on, output duty_level,
                  output dim_done, input ready);
  modport sink (input valid, input backlight_on, input duty_level,
                input dim_done, output ready);
endinterface

// ===== design/bkd_core.sv =====
// Keep-alive sequencer, dim-down timer and PWM state with per-item update.
module bkd_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  bkd_pkg::item_t        item,
  input  logic [15:0]           keepalive_ticks,
  input  logic [15:0]           dim_step_ticks,
  output bkd_pkg::result_t      res
);
  import bkd_pkg::*;

  // Compare width covers both the counter and the 16-bit registers
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  phase_t                keepalive_phase, keepalive_phase_next;
  dim_event_t            dim_event, dim_event_next;
  logic [COUNT_BITS-1:0] keepalive_count, keepalive_count_next;
  logic [COUNT_BITS-1:0] dim_tick_count, dim_tick_count_next;
  logic [DUTY_W-1:0]     duty, duty_next;
  logic [DUTY_W-1:0]     pwm_step, pwm_step_next;
  logic                  pin_level, pin_level_next;
  logic                  done;

  // Apply wake, slow tick, then fast tick to the current state
  always_comb begin
    keepalive_phase_next = keepalive_phase;
    keepalive_count_next = keepalive_count;
    dim_event_next       = dim_event;
    dim_tick_count_next  = dim_tick_count;
    duty_next            = duty;
    pwm_step_next        = pwm_step;
    pin_level_next       = pin_level;
    done                 = 1'b0;

    if (item.wake) begin
      keepalive_phase_next = PH_ARMED;
    end

    if (item.slow_tick) begin
      if (keepalive_phase_next == PH_ARMED) begin
        keepalive_count_next = '0;
        dim_event_next       = EV_HOLD;
        keepalive_phase_next = PH_COUNTING;
      end
      if (keepalive_phase_next == PH_COUNTING) begin
        keepalive_count_next = keepalive_count_next + 1'b1;
        if (CMP_W'(keepalive_count_next) == CMP_W'(keepalive_ticks)) begin
          dim_event_next       = EV_DIM;
          keepalive_phase_next = PH_IDLE;
        end
      end
    end

    if (item.fast_tick) begin
      case (dim_event_next)
        EV_DIM: begin
          dim_tick_count_next = dim_tick_count_next + 1'b1;
          if (CMP_W'(dim_tick_count_next) == CMP_W'(dim_step_ticks)) begin
            dim_tick_count_next = '0;
            duty_next = (duty_next > 4'd1) ? duty_next - 1'b1 : 4'd1;
            if (duty_next == 4'd1) begin
              dim_event_next = EV_NONE;
              done           = 1'b1;
            end
          end
        end
        EV_HOLD: begin
          duty_next           = PWM_STEPS;
          dim_tick_count_next = '0;
          dim_event_next      = EV_NONE;
        end
        default: ;
      endcase

      // Advance the PWM period
      pwm_step_next = pwm_step_next + 1'b1;
      if (pwm_step_next == PWM_STEPS) begin
        pwm_step_next  = '0;
        pin_level_next = (duty_next != '0);
      end
      if (pwm_step_next == duty_next) begin
        pin_level_next = 1'b0;
      end
    end
  end

  // Drive the result from the updated state
  always_comb begin
    res.backlight_on = pin_level_next;
    res.duty_level   = duty_next;
    res.dim_done     = done;
  end

  // Commit state when an item passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive_phase <= PH_IDLE;
      keepalive_count <= '0;
      dim_event       <= EV_NONE;
      dim_tick_count  <= '0;
      duty            <= '0;
      pwm_step        <= '0;
      pin_level       <= 1'b0;
    end else if (step) begin
      keepalive_phase <= keepalive_phase_next;
      keepalive_count <= keepalive_count_next;
      dim_event       <= dim_event_next;
      dim_tick_count  <= dim_tick_count_next;
      duty            <= duty_next;
      pwm_step        <= pwm_step_next;
      pin_level       <= pin_level_next;
    end
  end

endmodule

// ===== design/backlight_keepalive_dimmer_pwm.sv =====
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the receiver stalls; the state update is a
// single short pass of compares and increments between the two registers.
// Reset (synchronous, active high) sets both tick registers to 2000, the sequencer
// to idle with no pending dim event, duty, PWM step and pin to zero, and empties both
// pipeline registers. No clearing pass is needed.
module backlight_keepalive_dimmer_pwm #(
  parameter int COUNT_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  bkd_in_if.sink     item,
  bkd_out_if.source  result,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [15:0] cfg_data
);
  import bkd_pkg::*;

  `include "backlight_keepalive_dimmer_pwm_macros.svh"

  logic [CFG_W-1:0] keepalive_ticks;
  logic [CFG_W-1:0] dim_step_ticks;

  logic    s1_valid;
  item_t   s1_item;
  logic    s2_free;
  logic    s1_advance;
  result_t core_res;
  logic    out_valid;
  result_t out_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive_ticks <= 16'd2000;
      dim_step_ticks  <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEPALIVE: keepalive_ticks <= cfg_data;
        CFG_DIM_STEP:  dim_step_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s2_free    = !out_valid || result.ready;
  assign s1_advance = s1_valid && s2_free;
  assign item.ready = !s1_valid || s2_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= '{wake: item.wake, slow_tick: item.slow_tick,
                   fast_tick: item.fast_tick};
    end
  end

  bkd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (s1_advance),
    .item            (s1_item),
    .keepalive_ticks (keepalive_ticks),
    .dim_step_ticks  (dim_step_ticks),
    .res             (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_advance;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.backlight_on = out_res.backlight_on;
  assign result.duty_level   = out_res.duty_level;
  assign result.dim_done     = out_res.dim_done;

  // Checks on result consistency and pipeline hand-off
  `BKD_ASSERT_NOW(a_done_at_min, result.valid && result.dim_done, result.duty_level == 4'd1, "dim_done without minimum duty")
  `BKD_ASSERT_NOW(a_duty_range, result.valid, result.duty_level <= PWM_STEPS, "duty above PWM_STEPS")
  `BKD_ASSERT_NOW(a_pin_needs_duty, result.valid && result.backlight_on, result.duty_level != 4'd0, "pin lit at zero duty")
  `BKD_ASSERT_NEXT(a_transfer_held, item.valid && item.ready, s1_valid, "accepted item not held")

endmodule

// ===== tb/backlight_keepalive_dimmer_pwm_tb.sv =====
// Self-checking testbench for the backlight keep-alive dimmer with PWM output.
module backlight_keepalive_dimmer_pwm_tb;
  import bkd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  bkd_in_if in_ch ();
  bkd_out_if out_ch ();

  backlight_keepalive_dimmer_pwm dut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // One row of the directed table: a register write or an item.
  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [15:0] reg_val;
    item_t       it;
    bit          typed;
    result_t     want;
  } stim_row_t;

  // Predicted block state and register copies
  logic [15:0] ka_ticks;
  logic [15:0] dim_ticks;
  phase_t      ka_phase;
  logic [15:0] ka_count;
  dim_event_t  pend_event;
  logic [15:0] dim_count;
  logic [3:0]  duty;
  logic [3:0]  pwm_step;
  logic        pin;

  result_t   expected_levels[$];
  stim_row_t directed_rows[$];
  int        mismatches;
  int        burst_left;
  int        stall_left;
  int        stall_mode;
  int        cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic item_t mk_item(bit w, bit s, bit f);
    item_t it;
    it.wake = w;
    it.slow_tick = s;
    it.fast_tick = f;
    return it;
  endfunction

  function automatic result_t mk_level(bit on, logic [3:0] d, bit done);
    result_t r;
    r.backlight_on = on;
    r.duty_level = d;
    r.dim_done = done;
    return r;
  endfunction

  function automatic void add_item(item_t it, bit typed, result_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = CFG_KEEPALIVE;
    row.reg_val = '0;
    row.it = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic idx, logic [15:0] val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.it = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void reset_backlight();
    ka_ticks = 16'd2000;
    dim_ticks = 16'd2000;
    ka_phase = PH_IDLE;
    ka_count = '0;
    pend_event = EV_NONE;
    dim_count = '0;
    duty = '0;
    pwm_step = '0;
    pin = 1'b0;
  endfunction

  // Advance the predicted state by one item: wake, then slow tick, then fast tick.
  function automatic result_t advance_backlight(item_t it);
    result_t r;
    bit done;
    done = 1'b0;
    if (it.wake)
      ka_phase = PH_ARMED;
    if (it.slow_tick) begin
      if (ka_phase == PH_ARMED) begin
        ka_count = '0;
        pend_event = EV_HOLD;
        ka_phase = PH_COUNTING;
      end
      if (ka_phase == PH_COUNTING) begin
        ka_count = ka_count + 16'd1;
        if (ka_count == ka_ticks) begin
          pend_event = EV_DIM;
          ka_phase = PH_IDLE;
        end
      end
    end
    if (it.fast_tick) begin
      if (pend_event == EV_DIM) begin
        dim_count = dim_count + 16'd1;
        if (dim_count == dim_ticks) begin
          dim_count = '0;
          if (duty > 4'd1)
            duty = duty - 4'd1;
          else
            duty = 4'd1;
          if (duty == 4'd1) begin
            pend_event = EV_NONE;
            done = 1'b1;
          end
        end
      end else if (pend_event == EV_HOLD) begin
        duty = PWM_STEPS;
        dim_count = '0;
        pend_event = EV_NONE;
      end
      pwm_step = pwm_step + 4'd1;
      if (pwm_step == PWM_STEPS) begin
        pwm_step = '0;
        pin = (duty != 4'd0);
      end
      if (pwm_step == duty)
        pin = 1'b0;
    end
    r.backlight_on = pin;
    r.duty_level = duty;
    r.dim_done = done;
    return r;
  endfunction

  // Mostly fast ticks, some slow ticks and the odd wake, so sequences run to completion.
  function automatic item_t random_item();
    return mk_item($urandom_range(0, 99) < 3, $urandom_range(0, 99) < 20,
                   $urandom_range(0, 99) < 65);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH @%0t %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Drive one item in bursts with random gaps; record its expected level on transfer.
  task automatic send_item(item_t it, bit typed, result_t want);
    result_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.wake <= it.wake;
    in_ch.slow_tick <= it.slow_tick;
    in_ch.fast_tick <= it.fast_tick;
    do @(posedge clk); while (!in_ch.ready);
    r = advance_backlight(it);
    expected_levels.push_back(typed ? want : r);
  endtask

  // Write a register once the block has drained.
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEEPALIVE)
      ka_ticks = val;
    else
      dim_ticks = val;
  endtask

  // Receiver: alternate segments of always-ready, random, and mostly stalled.
  always @(negedge clk) begin : stall_pattern
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 20);
      stall_mode = $urandom_range(0, 2);
    end
    stall_left--;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin : check_levels
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("result with nothing pending, duty", out_ch.duty_level, 0);
      end else begin
        want = expected_levels.pop_front();
        if (out_ch.backlight_on !== want.backlight_on)
          report_mismatch("backlight_on", out_ch.backlight_on, want.backlight_on);
        if (out_ch.duty_level !== want.duty_level)
          report_mismatch("duty_level", out_ch.duty_level, want.duty_level);
        if (out_ch.dim_done !== want.dim_done)
          report_mismatch("dim_done", out_ch.dim_done, want.dim_done);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("backlight_keepalive_dimmer_pwm_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] ka_set[8];
    logic [15:0] dim_set[8];
    int          n_items[8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_KEEPALIVE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.wake = 1'b0;
    in_ch.slow_tick = 1'b0;
    in_ch.fast_tick = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    cycle_count = 0;
    reset_backlight();

    ka_set = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd0, 16'd65535, 16'd4, 16'd2000};
    dim_set = '{16'd1, 16'd3, 16'd1, 16'd4, 16'd0, 16'd65535, 16'd2, 16'd2000};
    n_items = '{250, 350, 250, 300, 150, 100, 350, 150};

    // Directed table: idle after reset, dimming from zero duty, a full dim-down
    add_item(mk_item(0, 0, 0), 1'b1, mk_level(0, 4'd0, 0));
    add_cfg(CFG_KEEPALIVE, 16'd1);
    add_cfg(CFG_DIM_STEP, 16'd1);
    add_item(mk_item(1, 1, 1), 1'b1, mk_level(0, 4'd1, 1));
    add_cfg(CFG_KEEPALIVE, 16'd2);
    add_item(mk_item(1, 0, 0), 1'b0, '0);
    add_item(mk_item(0, 1, 0), 1'b0, '0);
    add_item(mk_item(0, 0, 1), 1'b0, '0);
    add_item(mk_item(0, 1, 0), 1'b0, '0);
    for (int i = 0; i < 11; i++)
      add_item(mk_item(0, 0, 1), 1'b0, '0);
    add_item(mk_item(1, 1, 1), 1'b0, '0);
    add_item(mk_item(0, 1, 1), 1'b0, '0);
    add_item(mk_item(1, 0, 1), 1'b0, '0);
    add_item(mk_item(0, 1, 1), 1'b0, '0);
    add_item(mk_item(0, 0, 1), 1'b0, '0);

    // Hold reset, release on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random items under a range of register settings, extremes included
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_KEEPALIVE, ka_set[p]);
      write_reg(CFG_DIM_STEP, dim_set[p]);
      for (int n = 0; n < n_items[p]; n++)
        send_item(random_item(), 1'b0, '0);
    end

    // Drain and let any stray result show up
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("backlight_keepalive_dimmer_pwm_tb: done, clean");
    else
      $display("backlight_keepalive_dimmer_pwm_tb: done, errors");
    $finish;
  end

endmodule

// ===== backlight_keepalive_dimmer_pwm.f =====
+incdir+design
design/bkd_pkg.sv
design/bkd_if.sv
design/bkd_core.sv
design/backlight_keepalive_dimmer_pwm.sv
tb/backlight_keepalive_dimmer_pwm_tb.sv
